>>> rtl/assert_macros.svh
// Assertion macros shared by the checksum block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ICPH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ICPH_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/icph_pkg.sv
// Shared types, constants and helper functions of the checksum block.
`default_nettype none

package icph_pkg;

    // Operation codes on the input side
    typedef enum logic [1:0] {
        OP_DATA   = 2'd0,
        OP_ADDR   = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FAMILY = 2'd1,
        ST_LENGTH = 2'd2
    } status_t;

    localparam logic [15:0] LOW_BYTE_MASK  = 16'h00FF;
    localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;

    localparam int MID_QUEUE_DEPTH    = 2;
    localparam int RESULT_QUEUE_DEPTH = 2;

    // One finished packet handed from the front end to the back end
    typedef struct packed {
        logic [31:0] data_sum;
        logic [21:0] pseudo;
        logic        use_pseudo;
        logic        little_endian;
        status_t     status;
    } job_t;

    // One result item
    typedef struct packed {
        logic [15:0] checksum;
        status_t     status;
    } result_t;

    function automatic logic [15:0] swap16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    // Finish an end-around carry: a 17-bit partial sum to 16 bits
    function automatic logic [15:0] carry_in(input logic [16:0] v);
        logic [16:0] s;
        s = 17'(v[15:0]) + 17'(v[16]);
        return s[15:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/icph_fifo.sv
// Small first-in first-out queue built from registers.
`default_nettype none

module icph_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    input  wire T     wr_data,
    output logic      full,
    input  wire logic rd_take,
    output logic      rd_valid,
    output T          rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !full;
    assign do_rd    = rd_take && rd_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/icph_front.sv
// Front end: takes input items, keeps the running sums and emits finish jobs.
`default_nettype none

module icph_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          little_endian,
    input  wire logic          take,
    input  wire logic [1:0]    operation,
    input  wire logic [15:0]   data_word,
    input  wire logic [1:0]    byte_count,
    input  wire logic [31:0]   address_word,
    input  wire logic          use_pseudo,
    input  wire logic          family_ok,
    input  wire logic [7:0]    protocol,
    output logic               job_valid,
    output icph_pkg::job_t     job
);

    logic [31:0] data_sum_reg, data_sum_next;
    logic [20:0] address_sum_reg, address_sum_next;
    logic [15:0] byte_total_reg, byte_total_next;
    logic        length_overflow_reg, length_overflow_next;

    logic [1:0]  cnt_eff;
    logic [16:0] total_ext;
    logic [15:0] word_masked;
    logic [21:0] addr_raw;
    logic [21:0] addr_fold;
    logic [20:0] addr_sel;

    // Byte count three counts as two
    assign cnt_eff   = (byte_count == 2'd3) ? 2'd2 : byte_count;
    assign total_ext = {1'b0, byte_total_reg} + 17'(cnt_eff);

    // Odd trailing byte keeps only its valid half
    always_comb
    begin
        word_masked = data_word;
        if (cnt_eff == 2'd1)
        begin
            word_masked = data_word & (little_endian ? icph_pkg::LOW_BYTE_MASK
                                                     : icph_pkg::HIGH_BYTE_MASK);
        end
    end

    // Address halves into the address sum, folded once when bit 20 is reached
    assign addr_raw  = {1'b0, address_sum_reg} + 22'(address_word[15:0])
                     + 22'(address_word[31:16]);
    assign addr_fold = (addr_raw[21:20] != 2'b00)
                     ? 22'(addr_raw[15:0]) + 22'(addr_raw[21:16]) : addr_raw;

    // Next state of the sums
    always_comb
    begin
        data_sum_next        = data_sum_reg;
        address_sum_next     = address_sum_reg;
        byte_total_next      = byte_total_reg;
        length_overflow_next = length_overflow_reg;
        if (take)
        begin
            unique case (operation)
                icph_pkg::OP_DATA:
                begin
                    if (cnt_eff != 2'd0)
                    begin
                        if (total_ext[16])
                        begin
                            length_overflow_next = 1'b1;
                        end
                        else
                        begin
                            data_sum_next   = data_sum_reg + 32'(word_masked);
                            byte_total_next = total_ext[15:0];
                        end
                    end
                end
                icph_pkg::OP_ADDR:
                begin
                    address_sum_next = addr_fold[20:0];
                end
                icph_pkg::OP_FINISH:
                begin
                    data_sum_next        = '0;
                    address_sum_next     = '0;
                    byte_total_next      = '0;
                    length_overflow_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_sum_reg        <= '0;
            address_sum_reg     <= '0;
            byte_total_reg      <= '0;
            length_overflow_reg <= 1'b0;
        end
        else
        begin
            data_sum_reg        <= data_sum_next;
            address_sum_reg     <= address_sum_next;
            byte_total_reg      <= byte_total_next;
            length_overflow_reg <= length_overflow_next;
        end
    end

    // Finish job: pseudo sum of addresses, protocol and byte count, plus status
    assign addr_sel  = family_ok ? address_sum_reg : '0;
    assign job_valid = take && (operation == icph_pkg::OP_FINISH);

    always_comb
    begin
        job.data_sum      = data_sum_reg;
        job.pseudo        = '0;
        job.use_pseudo    = use_pseudo;
        job.little_endian = little_endian;
        job.status        = icph_pkg::ST_OK;
        if (use_pseudo)
        begin
            job.pseudo = {1'b0, addr_sel} + 22'(protocol) + 22'(byte_total_reg);
            if (!family_ok)
            begin
                job.status = icph_pkg::ST_FAMILY;
            end
        end
        if (length_overflow_reg)
        begin
            job.status = icph_pkg::ST_LENGTH;
        end
    end

endmodule

`default_nettype wire

>>> rtl/icph_back.sv
// Back end: two-stage pipeline that folds, complements and swaps the checksum.
`default_nettype none

module icph_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            job_valid,
    input  wire icph_pkg::job_t  job,
    output logic                 job_take,
    input  wire logic            res_ready,
    output logic                 res_valid,
    output icph_pkg::result_t    result
);

    logic                  s1_valid_reg;
    logic [31:0]           s1_data_sum_reg;
    logic [21:0]           s1_pseudo_reg;
    logic                  s1_le_reg;
    icph_pkg::status_t     s1_status_reg;

    logic                  s2_valid_reg;
    logic [31:0]           s2_sum_reg;
    logic                  s2_le_reg;
    icph_pkg::status_t     s2_status_reg;

    logic                  s1_ready, s2_ready;
    logic [16:0]           p_part;
    logic [15:0]           p_fold;
    logic [21:0]           p_val;
    logic [16:0]           g_part;
    logic [15:0]           g_fold;
    logic [15:0]           cs;

    // Stall chain back from the result queue
    assign s2_ready = !s2_valid_reg || res_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign job_take = job_valid && s1_ready;

    // Stage one: without a pseudo header the pseudo sum is zero; in little-endian mode it is folded and swapped
    assign p_part = 17'(job.pseudo[15:0]) + 17'(job.pseudo[21:16]);
    assign p_fold = icph_pkg::carry_in(p_part);

    always_comb
    begin
        p_val = '0;
        if (job.use_pseudo)
        begin
            p_val = job.little_endian ? 22'(icph_pkg::swap16(p_fold)) : job.pseudo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= job_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            s1_data_sum_reg <= job.data_sum;
            s1_pseudo_reg   <= p_val;
            s1_le_reg       <= job.little_endian;
            s1_status_reg   <= job.status;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_sum_reg    <= s1_data_sum_reg + 32'(s1_pseudo_reg);
            s2_le_reg     <= s1_le_reg;
            s2_status_reg <= s1_status_reg;
        end
    end

    // Output: fold the carries, complement, swap for little endian
    assign g_part = 17'(s2_sum_reg[15:0]) + 17'(s2_sum_reg[31:16]);
    assign g_fold = icph_pkg::carry_in(g_part);
    assign cs     = ~g_fold;

    assign res_valid       = s2_valid_reg;
    assign result.checksum = s2_le_reg ? icph_pkg::swap16(cs) : cs;
    assign result.status   = s2_status_reg;

endmodule

`default_nettype wire

>>> rtl/internet_checksum_pseudo_header_top.sv
// Top level of the internet checksum block with pseudo-header support.
`default_nettype none

`include "assert_macros.svh"

// Internet ones-complement checksum with optional pseudo header. Input items
// (data word, address word, finish) are taken one per cycle whenever full is
// low; data and address words only update the running sums. A finish item
// produces one result (checksum and status) for the result ports: the front
// end hands it to a small job queue, and a two-stage back-end pipeline folds,
// complements and swaps it into the result queue, where it is read out. full
// rises only when the job queue holds MID_DEPTH unfinished packets, which
// needs the result side to stall. The little_endian register is written over
// the cfg channel, which is always ready, and is to be changed only while the
// block is idle.
module internet_checksum_pseudo_header_top #(
    parameter int MID_DEPTH    = icph_pkg::MID_QUEUE_DEPTH,
    parameter int RESULT_DEPTH = icph_pkg::RESULT_QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Configuration write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_data,
    // Input queue side
    input  wire logic         push,
    output logic              full,
    input  wire logic [1:0]   operation,
    input  wire logic [15:0]  data_word,
    input  wire logic [1:0]   byte_count,
    input  wire logic [31:0]  address_word,
    input  wire logic         use_pseudo,
    input  wire logic         family_ok,
    input  wire logic [7:0]   protocol,
    // Result queue side
    output logic              empty,
    input  wire logic         pop,
    output logic [15:0]       checksum,
    output logic [1:0]        status
);

    logic                 little_endian_reg;
    logic                 take;
    logic                 job_valid;
    icph_pkg::job_t       job;
    logic                 mid_full;
    logic                 mid_valid;
    icph_pkg::job_t       mid_job;
    logic                 mid_take;
    logic                 res_push;
    logic                 res_full;
    icph_pkg::result_t    back_result;
    logic                 res_valid;
    icph_pkg::result_t    res_data;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            little_endian_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            little_endian_reg <= cfg_data;
        end
    end

    // Input transfer
    assign full = mid_full;
    assign take = push && !full;

    icph_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .little_endian (little_endian_reg),
        .take          (take),
        .operation     (operation),
        .data_word     (data_word),
        .byte_count    (byte_count),
        .address_word  (address_word),
        .use_pseudo    (use_pseudo),
        .family_ok     (family_ok),
        .protocol      (protocol),
        .job_valid     (job_valid),
        .job           (job)
    );

    icph_fifo #(
        .T     (icph_pkg::job_t),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (job_valid),
        .wr_data  (job),
        .full     (mid_full),
        .rd_take  (mid_take),
        .rd_valid (mid_valid),
        .rd_data  (mid_job)
    );

    icph_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (mid_valid),
        .job       (mid_job),
        .job_take  (mid_take),
        .res_ready (!res_full),
        .res_valid (res_push),
        .result    (back_result)
    );

    icph_fifo #(
        .T     (icph_pkg::result_t),
        .DEPTH (RESULT_DEPTH)
    ) u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_push),
        .wr_data  (back_result),
        .full     (res_full),
        .rd_take  (pop),
        .rd_valid (res_valid),
        .rd_data  (res_data)
    );

    // Result ports
    assign empty    = !res_valid;
    assign checksum = res_data.checksum;
    assign status   = res_data.status;

    // A taken finish is waiting in the job queue on the next cycle
    `ICPH_ASSERT(a_finish_queued, job_valid |=> mid_valid, "finish transfer lost")
    // A result held back by a full result queue stays offered
    `ICPH_ASSERT(a_res_hold, res_push && res_full |=> res_push, "stalled result dropped")
    // Front end never hands a job to a full job queue
    `ICPH_NEVER(a_mid_room, job_valid && mid_full, "job pushed into full queue")

endmodule

`default_nettype wire
